[hw/rtl/hrse_pkg.sv]
// Shared types, codes and helper functions of the hex record stream encoder.
package hrse_pkg;

  localparam int MaxRecord = 16;
  localparam int FillW = $clog2(MaxRecord + 1);
  localparam int BufIdxW = (MaxRecord > 1) ? $clog2(MaxRecord) : 1;
  // Byte index inside a record: four header bytes, the payload, the checksum.
  localparam int ByteIdxW = $clog2(MaxRecord + 5);

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
  localparam logic [7:0] REC_TYPE_ELA  = 8'h04;

  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;

  localparam logic [4:0] RecLenReset = 5'd16;
  // Register index taken from the word address bit of the config port.
  localparam logic REG_RECORD_LENGTH = 1'b0;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [7:0]  data;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       final_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLON,
    ST_HI,
    ST_LO,
    ST_CR,
    ST_LF
  } state_t;

  typedef enum logic [1:0] {
    REC_ELA,
    REC_DATA,
    REC_EOF
  } rec_kind_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'd0, nib};
    end else begin
      c = 7'h37 + {3'd0, nib};
    end
    return c;
  endfunction

endpackage

[hw/rtl/hrse_apb_regs.sv]
// Configuration register block: record length register with clamped limit output.
module hrse_apb_regs
  import hrse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [FillW-1:0] rec_limit
);

  logic [4:0] rec_len_r;
  logic [4:0] rec_len_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RECORD_LENGTH);

  always_comb begin
    rec_len_nxt = rec_len_r;
    if (wr_en) begin
      rec_len_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_len_r <= RecLenReset;
    end else begin
      rec_len_r <= rec_len_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_RECORD_LENGTH) ? {27'd0, rec_len_r} : 32'd0;

  // A length of zero acts as one, anything above the buffer size as the buffer size.
  always_comb begin
    if (rec_len_r == 5'd0) begin
      rec_limit = FillW'(1);
    end else if (32'(rec_len_r) > MaxRecord) begin
      rec_limit = FillW'(MaxRecord);
    end else begin
      rec_limit = FillW'(rec_len_r);
    end
  end

endmodule

[hw/rtl/hex_record_stream_encoder.sv]
// Intel HEX encoder top level: byte buffer, record sequencer and output register.
// A flush emits one character per cycle while out_stall is low: 13 + 2*n characters
// for a data record of n bytes, plus 17 when an extended linear address record comes
// first; the end item emits 13. The record sequencer and its shared checksum adder set
// this rate; no new item is taken while a record is emitted. Synchronous active-low
// reset clears all control state.
module hex_record_stream_encoder
  import hrse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FillW-1:0] rec_limit;

  hrse_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rec_limit (rec_limit)
  );

  state_t                state_r, state_nxt;
  rec_kind_t             kind_r, kind_nxt;
  logic [ByteIdxW-1:0]   idx_r, idx_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [15:0]           upper_r, upper_nxt;
  logic [31:0]           naddr_r, naddr_nxt;
  logic [FillW-1:0]      fill_r, fill_nxt;
  logic [7:0]            buf_r [MaxRecord];
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  in_acc;
  logic                  load;
  logic                  buf_we;
  logic [FillW-1:0]      fill_inc;
  logic [FillW-1:0]      pay_len;
  logic [ByteIdxW-1:0]   csum_idx;
  logic [ByteIdxW-1:0]   pay_idx;
  logic [7:0]            cur_byte;
  logic [7:0]            len_byte;
  logic [7:0]            ahi_byte;
  logic [7:0]            alo_byte;
  logic [7:0]            type_byte;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign fill_inc = (32'(fill_r) < MaxRecord) ? fill_r + FillW'(1) : fill_r;
  assign buf_we   = in_acc && (in_item.action == ACT_DATA) && (32'(fill_r) < MaxRecord);

  // Byte selection for the record being emitted.
  always_comb begin
    len_byte  = 8'd0;
    ahi_byte  = 8'd0;
    alo_byte  = 8'd0;
    type_byte = REC_TYPE_EOF;
    pay_len   = '0;
    case (kind_r)
      REC_ELA: begin
        len_byte  = 8'd2;
        type_byte = REC_TYPE_ELA;
        pay_len   = FillW'(2);
      end
      REC_DATA: begin
        len_byte  = 8'(fill_r);
        ahi_byte  = naddr_r[15:8];
        alo_byte  = naddr_r[7:0];
        type_byte = REC_TYPE_DATA;
        pay_len   = fill_r;
      end
      default: begin
        len_byte  = 8'd0;
        type_byte = REC_TYPE_EOF;
        pay_len   = '0;
      end
    endcase
  end

  assign csum_idx = ByteIdxW'(pay_len) + ByteIdxW'(4);
  assign pay_idx  = idx_r - ByteIdxW'(4);

  always_comb begin
    case (idx_r)
      ByteIdxW'(0): cur_byte = len_byte;
      ByteIdxW'(1): cur_byte = ahi_byte;
      ByteIdxW'(2): cur_byte = alo_byte;
      ByteIdxW'(3): cur_byte = type_byte;
      default: begin
        if (idx_r == csum_idx) begin
          cur_byte = 8'd0 - sum_r;
        end else if (kind_r == REC_ELA) begin
          cur_byte = pay_idx[0] ? naddr_r[23:16] : naddr_r[31:24];
        end else begin
          cur_byte = buf_r[pay_idx[BufIdxW-1:0]];
        end
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    upper_nxt     = upper_r;
    naddr_nxt     = naddr_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (load) begin
      out_valid_nxt = (state_r != ST_IDLE);
      out_item_nxt.final_res = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.action)
            ACT_START: begin
              naddr_nxt = in_item.address;
              upper_nxt = 16'd0;
              fill_nxt  = '0;
            end
            ACT_DATA: begin
              fill_nxt = fill_inc;
              if ((fill_inc >= rec_limit) || in_item.last) begin
                idx_nxt   = '0;
                state_nxt = ST_COLON;
                if (naddr_r[31:16] != upper_r) begin
                  upper_nxt = naddr_r[31:16];
                  kind_nxt  = REC_ELA;
                end else begin
                  kind_nxt  = REC_DATA;
                end
              end
            end
            ACT_END: begin
              fill_nxt  = '0;
              kind_nxt  = REC_EOF;
              idx_nxt   = '0;
              state_nxt = ST_COLON;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_COLON: begin
        if (load) begin
          out_item_nxt.character = CH_COLON;
          sum_nxt   = 8'd0;
          idx_nxt   = '0;
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        if (load) begin
          out_item_nxt.character = hex_char(cur_byte[7:4]);
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        if (load) begin
          out_item_nxt.character = hex_char(cur_byte[3:0]);
          sum_nxt = sum_r + cur_byte;
          if (idx_r == csum_idx) begin
            state_nxt = ST_CR;
          end else begin
            idx_nxt   = idx_r + ByteIdxW'(1);
            state_nxt = ST_HI;
          end
        end
      end
      ST_CR: begin
        if (load) begin
          out_item_nxt.character = CH_CR;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (load) begin
          out_item_nxt.character = CH_LF;
          out_item_nxt.final_res = (kind_r != REC_ELA);
          if (kind_r == REC_ELA) begin
            // The address record is always followed by the data record.
            kind_nxt  = REC_DATA;
            state_nxt = ST_COLON;
          end else begin
            if (kind_r == REC_DATA) begin
              naddr_nxt = naddr_r + 32'(fill_r);
              fill_nxt  = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= REC_EOF;
      idx_r       <= '0;
      sum_r       <= 8'd0;
      upper_r     <= 16'd0;
      naddr_r     <= 32'd0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      upper_r     <= upper_nxt;
      naddr_r     <= naddr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (buf_we) begin
      buf_r[fill_r[BufIdxW-1:0]] <= in_item.data;
    end
  end

endmodule

[tb/sv/hex_text_checker.sv]
// Checker for the hex record encoder: predicts the HEX text and compares every output word.
`timescale 1ns / 100ps

module hex_text_checker
  import hrse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        fail_count,
  output int unsigned        backlog
);

  localparam logic [2:0] REC_LEN_ADDR = {REG_RECORD_LENGTH, 2'b00};

  // Mirror of the encoder state.
  logic [4:0]  rec_len;
  logic [15:0] upper_seen;
  logic [31:0] next_addr;
  logic [7:0]  held [MaxRecord];
  int unsigned held_cnt;
  logic [7:0]  rec_sum;

  logic [6:0]  line_chars [$];
  out_item_t   expected_text [$];

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + 7'(nib);
    end
    return 7'h41 + 7'(nib - 4'd10);
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    rec_sum = rec_sum + b;
    line_chars.push_back(hex_digit(b[7:4]));
    line_chars.push_back(hex_digit(b[3:0]));
  endfunction

  function automatic void open_rec(input logic [7:0] len, input logic [15:0] addr16,
                                   input logic [7:0] kind);
    rec_sum = 8'h00;
    line_chars.push_back(CH_COLON);
    put_hex(len);
    put_hex(addr16[15:8]);
    put_hex(addr16[7:0]);
    put_hex(kind);
  endfunction

  function automatic void close_rec();
    put_hex(8'h00 - rec_sum);
    line_chars.push_back(CH_CR);
    line_chars.push_back(CH_LF);
  endfunction

  function automatic void flush_held();
    logic [15:0] hi;
    hi = next_addr[31:16];
    // The upper address is only compared at the start of a record.
    if (hi != upper_seen) begin
      upper_seen = hi;
      open_rec(8'd2, 16'h0000, REC_TYPE_ELA);
      put_hex(hi[15:8]);
      put_hex(hi[7:0]);
      close_rec();
    end
    open_rec(8'(held_cnt), next_addr[15:0], REC_TYPE_DATA);
    for (int i = 0; i < held_cnt; i++) begin
      put_hex(held[i]);
    end
    close_rec();
    next_addr = next_addr + held_cnt;
    held_cnt = 0;
  endfunction

  function automatic void encode_word(input in_item_t w);
    int unsigned limit;
    limit = 32'(rec_len);
    if (limit < 1) limit = 1;
    if (limit > MaxRecord) limit = MaxRecord;
    case (w.action)
      ACT_START: begin
        next_addr = w.address;
        upper_seen = 16'h0000;
        held_cnt = 0;
      end
      ACT_DATA: begin
        if (held_cnt < MaxRecord) begin
          held[held_cnt] = w.data;
          held_cnt++;
        end
        if (held_cnt >= limit || w.last) flush_held();
      end
      ACT_END: begin
        held_cnt = 0;
        open_rec(8'd0, 16'h0000, REC_TYPE_EOF);
        close_rec();
      end
      default: ;
    endcase
    for (int i = 0; i < line_chars.size(); i++) begin
      expected_text.push_back('{character: line_chars[i],
                                final_res: (i == line_chars.size() - 1)});
    end
    line_chars.delete();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rec_len = RecLenReset;
      upper_seen = 16'h0000;
      next_addr = 32'h0;
      held_cnt = 0;
      rec_sum = 8'h00;
      expected_text.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REC_LEN_ADDR) begin
        rec_len = pwdata[4:0];
      end
      // Outputs seen at this edge belong to earlier words, so they go first.
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected output word: char %h final %b",
                     out_item.character, out_item.final_res);
          end
        end else begin
          out_item_t want;
          want = expected_text.pop_front();
          if (out_item.character !== want.character) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("character mismatch: expected %h got %h",
                       want.character, out_item.character);
            end
          end
          if (out_item.final_res !== want.final_res) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("final flag mismatch on char %h: expected %b got %b",
                       want.character, want.final_res, out_item.final_res);
            end
          end
        end
      end
      if (in_valid && !in_stall) encode_word(in_item);
    end
    backlog = expected_text.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the hex record encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import hrse_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] REC_LEN_ADDR = {REG_RECORD_LENGTH, 2'b00};
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned phase_words;
  int unsigned stall_left = 0;
  int unsigned out_gap;
  int unsigned idle_cycles = 0;
  logic        quiet = 1'b0;
  logic [4:0]  len_plan [8];

  always #5 clk = ~clk;

  hex_record_stream_encoder dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hex_text_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .backlog
  );

  // Receiver: after each accepted word it may hold stall, except in the quiet phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_valid && !out_stall) begin
      out_gap = quiet ? 0 : $urandom_range(0, 15);
      out_stall <= (out_gap != 0);
      stall_left <= (out_gap != 0) ? out_gap - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_word(input logic [1:0] act, input logic [31:0] addr,
                                         input logic [7:0] dat, input logic lst);
    in_item_t w;
    w.action = act;
    w.address = addr;
    w.data = dat;
    w.last = lst;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (w.action != ACT_UNUSED) phase_words++;
  endtask

  task automatic send_data(input logic [7:0] dat, input logic lst);
    send_word(make_word(ACT_DATA, $urandom, dat, lst));
  endtask

  // Called in the step of the last acceptance, so in_valid gets one update here.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One region: usually a start, then a run of bytes, sometimes an end or a junk word.
  task automatic run_region();
    int unsigned n;
    logic [31:0] base;
    logic lst;
    case ($urandom_range(0, 7))
      0: base = 32'hFFFF_FFE0 | 32'($urandom_range(0, 31));
      1: base = {16'($urandom), 16'hFFE0 | 16'($urandom_range(0, 31))};
      2: base = {16'h0000, 16'($urandom)};
      default: base = $urandom;
    endcase
    if ($urandom_range(0, 5) != 0) begin
      send_word(make_word(ACT_START, base, 8'($urandom), 1'($urandom)));
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      lst = (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
      send_data(8'($urandom), lst);
    end
    if ($urandom_range(0, 4) == 0) begin
      send_word(make_word(ACT_END, $urandom, 8'($urandom), 1'($urandom)));
    end
    if ($urandom_range(0, 9) == 0) begin
      send_word(make_word(ACT_UNUSED, $urandom, 8'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    len_plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd4, 5'd9};
    len_plan[6] = 5'($urandom_range(2, 15));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes before any start go out at address zero.
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b1);
    send_word(make_word(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    // This record straddles a 64K boundary and needs an extended address first.
    send_word(make_word(ACT_START, 32'h0001_FFFE, 8'hFF, 1'b1));
    send_data(8'h5A, 1'b0);
    send_data(8'hC3, 1'b0);
    send_data(8'h81, 1'b1);
    // A start drops the byte that is still buffered.
    send_data(8'hA5, 1'b0);
    send_word(make_word(ACT_START, 32'hFFFF_FFFF, 8'h00, 1'b0));
    // The address wraps past the top, so the next record goes back to upper zero.
    send_data(8'h12, 1'b0);
    send_data(8'h34, 1'b1);
    send_data(8'h7E, 1'b1);
    send_data(8'h01, 1'b0);
    send_word(make_word(ACT_END, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_word(make_word(ACT_END, 32'h0000_0000, 8'h00, 1'b0));

    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        settle();
        write_reg(REC_LEN_ADDR, {27'($urandom), len_plan[phase]});
      end
      quiet <= (phase == 2 || phase == 5);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) run_region();
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[hex_record_stream_encoder.f]
hw/rtl/hrse_pkg.sv
hw/rtl/hrse_apb_regs.sv
hw/rtl/hex_record_stream_encoder.sv
tb/sv/hex_text_checker.sv
tb/sv/tb_top.sv
